[hdl/ffea_pkg.sv]
// ffea_pkg: shared constants and types of the first-fit extent allocator
// no dependencies; used by ffea_cell and first_fit_extent_allocator_top
package ffea_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int ADDR_BITS_DEF   = 24;
    localparam int NAME_BYTES_DEF  = 20;

    localparam int LEN_W   = 25;
    localparam int CAP_W   = 25;
    localparam int STAT_W  = 3;
    localparam int IN_NAME_BYTES = 20;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 25'd9437184;

    localparam logic [1:0] REQ_ALLOC  = 2'd0;
    localparam logic [1:0] REQ_DELETE = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd2;
    localparam logic [STAT_W-1:0] ST_NO_SPACE  = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;

    localparam logic [1:0] REG_CAPACITY = 2'd0;

    typedef struct packed {
        logic rotate;
        logic insert;
        logic remove;
    } cell_ctrl_t;

endpackage

[hdl/ffea_cell.sv]
// ffea_cell: one table entry of the extent chain (start, length, name)
// depends on ffea_pkg; rotates, inserts and removes with its neighbors
module ffea_cell #(
    parameter int TABLE_DEPTH = ffea_pkg::TABLE_DEPTH_DEF,
    parameter int ADDR_BITS   = ffea_pkg::ADDR_BITS_DEF,
    parameter int NAME_BYTES  = ffea_pkg::NAME_BYTES_DEF,
    parameter int IDX         = 0
) (
    input  logic                                  clk,
    input  ffea_pkg::cell_ctrl_t                  ctrl,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0]      ins_pos,
    input  logic [$clog2(TABLE_DEPTH)-1:0]        del_idx,
    input  logic [ADDR_BITS-1:0]                  new_start,
    input  logic [ffea_pkg::LEN_W-1:0]            new_len,
    input  logic [8*NAME_BYTES-1:0]               new_name,
    input  logic [ADDR_BITS-1:0]                  left_start,
    input  logic [ffea_pkg::LEN_W-1:0]            left_len,
    input  logic [8*NAME_BYTES-1:0]               left_name,
    input  logic [ADDR_BITS-1:0]                  right_start,
    input  logic [ffea_pkg::LEN_W-1:0]            right_len,
    input  logic [8*NAME_BYTES-1:0]               right_name,
    output logic [ADDR_BITS-1:0]                  start,
    output logic [ffea_pkg::LEN_W-1:0]            len,
    output logic [8*NAME_BYTES-1:0]               name
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH+1);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
    localparam logic [CNT_W-1:0] MY_POS = CNT_W'(IDX);

    logic [ADDR_BITS-1:0]       start_reg, start_next;
    logic [ffea_pkg::LEN_W-1:0] len_reg, len_next;
    logic [8*NAME_BYTES-1:0]    name_reg, name_next;

    always_comb
    begin
        start_next = start_reg;
        len_next   = len_reg;
        name_next  = name_reg;
        if (ctrl.rotate || (ctrl.remove && MY_IDX >= del_idx))
        begin
            start_next = right_start;
            len_next   = right_len;
            name_next  = right_name;
        end
        else if (ctrl.insert && MY_POS > ins_pos)
        begin
            start_next = left_start;
            len_next   = left_len;
            name_next  = left_name;
        end
        else if (ctrl.insert && MY_POS == ins_pos)
        begin
            start_next = new_start;
            len_next   = new_len;
            name_next  = new_name;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        len_reg   <= len_next;
        name_reg  <= name_next;
    end

    assign start = start_reg;
    assign len   = len_reg;
    assign name  = name_reg;

endmodule

[hdl/first_fit_extent_allocator_top.sv]
// a request passes the scan, apply and out states in order; clear skips the scan
// a new request is taken only back in idle; the scan is one full rotation of the
// entry ring, which brings every entry past the head cell once
// a new request is taken while the previous result still waits on the output
// reset (rst_n, asynchronous, active low) empties the table and sets capacity to 9437184
// first_fit_extent_allocator_top: scan control, apb register and chain of ffea_cell
module first_fit_extent_allocator_top #(
    parameter int TABLE_DEPTH = ffea_pkg::TABLE_DEPTH_DEF,
    parameter int ADDR_BITS   = ffea_pkg::ADDR_BITS_DEF,
    parameter int NAME_BYTES  = ffea_pkg::NAME_BYTES_DEF,
    localparam int OUT_BITS   = ffea_pkg::STAT_W + ADDR_BITS + ffea_pkg::LEN_W,
    localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    // name_word0, name_word1, name_word2, alloc_length
    input  logic [191:0]       s_tdata,
    // req_type
    input  logic [1:0]         s_tuser,
    output logic               m_tvalid,
    input  logic               m_tready,
    // status, extent_start, extent_length
    output logic [OUT_W-1:0]   m_tdata,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int CNT_W   = $clog2(TABLE_DEPTH+1);
    localparam int NAME_W  = 8 * NAME_BYTES;
    localparam int LEN_W   = ffea_pkg::LEN_W;
    localparam int SUM_W   = ((ADDR_BITS > 26) ? ADDR_BITS : 26) + 1;
    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(TABLE_DEPTH);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_APPLY, S_OUT} state_t;

    state_t                     state_reg, state_next;
    logic [ffea_pkg::CAP_W-1:0] capacity_reg, capacity_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [IDX_W-1:0]           step_reg, step_next;
    logic [1:0]                 req_reg, req_next;
    logic [NAME_W-1:0]          rname_reg, rname_next;
    logic [LEN_W-1:0]           rlen_reg, rlen_next;
    logic                       hit_reg, hit_next;
    logic [IDX_W-1:0]           hidx_reg, hidx_next;
    logic [ADDR_BITS-1:0]       hstart_reg, hstart_next;
    logic [LEN_W-1:0]           hlen_reg, hlen_next;
    logic                       placed_reg, placed_next;
    logic [ADDR_BITS-1:0]       where_reg, where_next;
    logic [CNT_W-1:0]           pos_reg, pos_next;
    logic [ADDR_BITS-1:0]       pstart_reg, pstart_next;
    logic [LEN_W-1:0]           plen_reg, plen_next;
    logic [ffea_pkg::STAT_W-1:0] rstat_reg, rstat_next;
    logic [ADDR_BITS-1:0]       rs_reg, rs_next;
    logic [LEN_W-1:0]           rl_reg, rl_next;
    logic                       mvalid_reg, mvalid_next;
    logic [OUT_W-1:0]           mdata_reg, mdata_next;

    logic [ADDR_BITS-1:0]       c_start [TABLE_DEPTH];
    logic [LEN_W-1:0]           c_len [TABLE_DEPTH];
    logic [NAME_W-1:0]          c_name [TABLE_DEPTH];
    ffea_pkg::cell_ctrl_t       cctrl;
    logic [CNT_W-1:0]           ins_pos;
    logic [ADDR_BITS-1:0]       ins_start;

    logic [255:0]               raw_name;
    logic [NAME_W-1:0]          in_name;
    logic                       ended;
    logic [7:0]                 nbyte;

    logic                       step_valid;
    logic [SUM_W-1:0]           head_start_w, head_len_w, prev_end, tail_end, cap_w;
    logic                       fit_now;
    logic [ADDR_BITS-1:0]       cand_where;
    logic                       in_fire, cfg_wr;

    assign in_fire = s_tvalid && s_tready;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign prdata  = (paddr == ffea_pkg::REG_CAPACITY) ? 32'(capacity_reg) : 32'd0;

    // name ends at its first nul byte
    always_comb
    begin
        raw_name = {96'd0, s_tdata[159:0]};
        ended    = 1'b0;
        in_name  = '0;
        for (int b = 0; b < NAME_BYTES; b++)
        begin
            nbyte = (b < ffea_pkg::IN_NAME_BYTES) ? raw_name[8*b +: 8] : 8'd0;
            if (nbyte == 8'd0)
            begin
                ended = 1'b1;
            end
            in_name[8*b +: 8] = ended ? 8'd0 : nbyte;
        end
    end

    assign step_valid   = CNT_W'(step_reg) < count_reg;
    assign head_start_w = SUM_W'(c_start[0]);
    assign head_len_w   = SUM_W'(rlen_reg);
    assign prev_end     = SUM_W'(pstart_reg) + SUM_W'(plen_reg);
    assign tail_end     = prev_end;
    assign cap_w        = SUM_W'(capacity_reg);

    always_comb
    begin
        fit_now    = 1'b0;
        cand_where = '0;
        if (step_reg == '0)
        begin
            fit_now    = head_len_w <= head_start_w;
            cand_where = ADDR_BITS'(head_start_w - head_len_w);
        end
        else
        begin
            fit_now    = prev_end + head_len_w <= head_start_w;
            cand_where = ADDR_BITS'(prev_end);
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        capacity_next = cfg_wr && paddr == ffea_pkg::REG_CAPACITY ?
                        pwdata[ffea_pkg::CAP_W-1:0] : capacity_reg;
        count_next    = count_reg;
        step_next     = step_reg;
        req_next      = req_reg;
        rname_next    = rname_reg;
        rlen_next     = rlen_reg;
        hit_next      = hit_reg;
        hidx_next     = hidx_reg;
        hstart_next   = hstart_reg;
        hlen_next     = hlen_reg;
        placed_next   = placed_reg;
        where_next    = where_reg;
        pos_next      = pos_reg;
        pstart_next   = pstart_reg;
        plen_next     = plen_reg;
        rstat_next    = rstat_reg;
        rs_next       = rs_reg;
        rl_next       = rl_reg;
        mvalid_next   = mvalid_reg && !m_tready;
        mdata_next    = mdata_reg;
        cctrl         = '0;
        ins_pos       = pos_reg;
        ins_start     = where_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    req_next    = s_tuser;
                    rname_next  = in_name;
                    rlen_next   = s_tdata[160 +: LEN_W];
                    hit_next    = 1'b0;
                    placed_next = 1'b0;
                    step_next   = '0;
                    state_next  = (s_tuser == ffea_pkg::REQ_CLEAR) ? S_APPLY : S_SCAN;
                end
            end
            S_SCAN:
            begin
                cctrl.rotate = 1'b1;
                if (step_valid)
                begin
                    pstart_next = c_start[0];
                    plen_next   = c_len[0];
                    if (!hit_reg && c_name[0] == rname_reg)
                    begin
                        hit_next    = 1'b1;
                        hidx_next   = step_reg;
                        hstart_next = c_start[0];
                        hlen_next   = c_len[0];
                    end
                    if (!placed_reg && fit_now)
                    begin
                        placed_next = 1'b1;
                        where_next  = cand_where;
                        pos_next    = CNT_W'(step_reg) + CNT_W'(c_start[0] <= cand_where);
                    end
                    else if (placed_reg)
                    begin
                        pos_next = pos_reg + CNT_W'(c_start[0] <= where_reg);
                    end
                end
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                rstat_next = ffea_pkg::ST_OK;
                rs_next    = '0;
                rl_next    = '0;
                state_next = S_OUT;
                case (req_reg) inside
                    ffea_pkg::REQ_ALLOC:
                    begin
                        if (hit_reg)
                        begin
                            rstat_next = ffea_pkg::ST_DUPLICATE;
                        end
                        else if (count_reg == FULL_CNT)
                        begin
                            rstat_next = ffea_pkg::ST_FULL;
                        end
                        else if (placed_reg || count_reg == '0)
                        begin
                            ins_pos      = placed_reg ? pos_reg : '0;
                            ins_start    = placed_reg ? where_reg : '0;
                            cctrl.insert = 1'b1;
                            count_next   = count_reg + 1'b1;
                            rs_next      = ins_start;
                            rl_next      = rlen_reg;
                        end
                        else if (tail_end + head_len_w <= cap_w &&
                                 tail_end[SUM_W-1:ADDR_BITS] == '0)
                        begin
                            ins_pos      = count_reg;
                            ins_start    = ADDR_BITS'(tail_end);
                            cctrl.insert = 1'b1;
                            count_next   = count_reg + 1'b1;
                            rs_next      = ins_start;
                            rl_next      = rlen_reg;
                        end
                        else
                        begin
                            rstat_next = ffea_pkg::ST_NO_SPACE;
                        end
                    end
                    ffea_pkg::REQ_DELETE, ffea_pkg::REQ_LOOKUP:
                    begin
                        if (!hit_reg)
                        begin
                            rstat_next = ffea_pkg::ST_NOT_FOUND;
                        end
                        else
                        begin
                            rs_next = hstart_reg;
                            rl_next = hlen_reg;
                            if (req_reg == ffea_pkg::REQ_DELETE)
                            begin
                                cctrl.remove = 1'b1;
                                count_next   = count_reg - 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        count_next = '0;
                    end
                endcase
            end
            S_OUT:
            begin
                if (!mvalid_reg || m_tready)
                begin
                    mvalid_next = 1'b1;
                    mdata_next  = OUT_W'({rl_reg, rs_reg, rstat_reg});
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            capacity_reg <= ffea_pkg::CAPACITY_RESET;
            count_reg    <= '0;
            mvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            capacity_reg <= capacity_next;
            count_reg    <= count_next;
            mvalid_reg   <= mvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg   <= step_next;
        req_reg    <= req_next;
        rname_reg  <= rname_next;
        rlen_reg   <= rlen_next;
        hit_reg    <= hit_next;
        hidx_reg   <= hidx_next;
        hstart_reg <= hstart_next;
        hlen_reg   <= hlen_next;
        placed_reg <= placed_next;
        where_reg  <= where_next;
        pos_reg    <= pos_next;
        pstart_reg <= pstart_next;
        plen_reg   <= plen_next;
        rstat_reg  <= rstat_next;
        rs_reg     <= rs_next;
        rl_reg     <= rl_next;
        mdata_reg  <= mdata_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

    // ring of entries: right neighbor of the last cell is the head cell
    for (genvar k = 0; k < TABLE_DEPTH; k++)
    begin : g_cell
        localparam int RK = (k == TABLE_DEPTH - 1) ? 0 : k + 1;
        localparam int LK = (k == 0) ? TABLE_DEPTH - 1 : k - 1;
        ffea_cell #(
            .TABLE_DEPTH (TABLE_DEPTH),
            .ADDR_BITS   (ADDR_BITS),
            .NAME_BYTES  (NAME_BYTES),
            .IDX         (k)
        ) u_cell (
            .clk         (clk),
            .ctrl        (cctrl),
            .ins_pos     (ins_pos),
            .del_idx     (hidx_reg),
            .new_start   (ins_start),
            .new_len     (rlen_reg),
            .new_name    (rname_reg),
            .left_start  (c_start[LK]),
            .left_len    (c_len[LK]),
            .left_name   (c_name[LK]),
            .right_start (c_start[RK]),
            .right_len   (c_len[RK]),
            .right_name  (c_name[RK]),
            .start       (c_start[k]),
            .len         (c_len[k]),
            .name        (c_name[k])
        );
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("entry count above table depth");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg > $past(count_reg) |-> count_reg == $past(count_reg) + 1'b1)
        else $error("entry count grew by more than one");
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while one is in work");
`endif

endmodule
